@@ design/hit_to_trigger_primitive_formatter_assert.svh @@
// Assertion helpers shared by the formatter RTL.
// Both macros disable the check while the active-low reset is asserted.
`ifndef HIT_TO_TRIGGER_PRIMITIVE_FORMATTER_ASSERT_SVH
`define HIT_TO_TRIGGER_PRIMITIVE_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define HTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htp assertion failed");

// Next-cycle implication.
`define HTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htp assertion failed");

`endif

@@ design/htp_pkg.sv @@
package htp_pkg;

    // Operation codes of an input beat
    localparam logic OpHit      = 1'b0;
    localparam logic OpMapWrite = 1'b1;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgTickClocks = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMaxWidth   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgNoHitMark  = 2'd2;
    localparam int CfgDataW = 24;

    // Reset values of the configuration registers
    localparam logic [7:0]  TickClocksRst = 8'd32;
    localparam logic [23:0] MaxWidthRst   = 24'hFF_FFFF;
    localparam logic [15:0] NoHitMarkRst  = 16'hFFFF;

    // Charge / 20 as multiply by a rounded-up reciprocal and a shift;
    // exact for every 16-bit charge.
    localparam int AdcPeakDiv   = 20;
    localparam int AdcRecipShift = 20;
    localparam logic [15:0] AdcRecip = 16'(((2 ** AdcRecipShift) + AdcPeakDiv - 1) / AdcPeakDiv);

    typedef struct packed {
        logic        op;
        logic [15:0] reg_channel;
        logic [15:0] hit_end;
        logic [15:0] charge;
        logic [15:0] tover;
        logic [63:0] frame_time;
        logic [15:0] map_offline;
        logic        map_masked;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] start_time;
        logic [63:0] peak_time;
        logic [23:0] time_over;
        logic [15:0] offl_chan;
        logic [15:0] charge_int;
        logic [11:0] charge_pk;
        logic        too_long;
        logic [31:0] dropped_total;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] offline;
        logic        masked;
    } t_map_entry;

endpackage

@@ design/hit_to_trigger_primitive_formatter.sv @@
// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall  t_in_beat (hit record or map write)
// out       output     o_out_valid/i_out_stall t_out_beat (trigger primitive)
// cfg       input      i_cfg_we (no stall)    i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained unless the output stalls; a primitive is valid on the
// output once it has passed the registered map read, multiply and add/format stages.
// Map writes and suppressed hits produce no output beat and drop out of the pipe.
// Reset (synchronous, active low) clears the stage valids, the drop counter and the
// configuration registers; the channel map itself is not cleared.
// A stall on the output backs up only through full stages; bubbles are squeezed out.
module hit_to_trigger_primitive_formatter #(
    parameter int NUM_CHANNELS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  htp_pkg::t_in_beat               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output htp_pkg::t_out_beat              o_out,
    input  logic                            i_cfg_we,
    input  logic [htp_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [htp_pkg::CfgDataW-1:0]    i_cfg_data
);
    import htp_pkg::*;

    `include "hit_to_trigger_primitive_formatter_assert.svh"

    localparam int IdxW = $clog2(NUM_CHANNELS);
    localparam logic [16:0] ChanLimit = 17'(NUM_CHANNELS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0]  r_tick;
    logic [23:0] r_max_width;
    logic [15:0] r_no_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= TickClocksRst;
            r_max_width <= MaxWidthRst;
            r_no_hit    <= NoHitMarkRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgTickClocks: r_tick      <= i_cfg_data[7:0];
                CfgMaxWidth:   r_max_width <= i_cfg_data;
                CfgNoHitMark:  r_no_hit    <= i_cfg_data[15:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or
    // when the stage after it advances.
    // ---------------------------------------------------------------
    logic r_s1_v;
    logic r_s2_v;
    logic r_out_v;
    logic en_out;
    logic en2;
    logic en1;
    logic in_acc;

    assign en_out     = !r_out_v || !i_out_stall;
    assign en2        = !r_s2_v || en_out;
    assign en1        = !r_s1_v || en2;
    assign o_in_stall = !en1;
    assign in_acc     = i_in_valid && en1;

    // ---------------------------------------------------------------
    // Stage 1: screen the record and look up the channel map
    // ---------------------------------------------------------------
    logic       chan_in_range;
    logic       hit_kill;
    logic       map_we;
    t_map_entry map_wdata;
    t_map_entry map_rdata;
    t_in_beat   r_s1_in;

    assign chan_in_range = {1'b0, i_in.reg_channel} < ChanLimit;
    // Empty charge, empty lane or channel off the map: no primitive.
    assign hit_kill  = (i_in.charge == 16'd0) || (i_in.reg_channel == r_no_hit)
                       || !chan_in_range;
    assign map_we    = in_acc && (i_in.op == OpMapWrite) && chan_in_range;
    assign map_wdata = '{offline: i_in.map_offline, masked: i_in.map_masked};

    htp_chan_map #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_chan_map (
        .i_clk     (i_clk),
        .i_rd_en   (en1),
        .i_wr_en   (map_we),
        .i_addr    (i_in.reg_channel[IdxW-1:0]),
        .i_wr_data (map_wdata),
        .o_rd_data (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en1) begin
            r_s1_v <= in_acc && (i_in.op == OpHit) && !hit_kill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_in <= i_in;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: apply the mask, scale by the tick, divide the charge
    // ---------------------------------------------------------------
    logic [23:0] r_s2_end_clk;
    logic [23:0] r_s2_tover_clk;
    logic [63:0] r_s2_ts;
    logic [15:0] r_s2_charge;
    logic [11:0] r_s2_charge_pk;
    logic [15:0] r_s2_offline;
    logic [31:0] n2_recip_prod;

    assign n2_recip_prod = 32'(r_s1_in.charge) * 32'(AdcRecip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en2) begin
            r_s2_v <= r_s1_v && !map_rdata.masked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_end_clk   <= 24'(r_tick) * 24'(r_s1_in.hit_end);
            r_s2_tover_clk <= 24'(r_tick) * 24'(r_s1_in.tover);
            r_s2_ts        <= r_s1_in.frame_time;
            r_s2_charge    <= r_s1_in.charge;
            r_s2_charge_pk <= n2_recip_prod[AdcRecipShift +: 12];
            r_s2_offline   <= map_rdata.offline;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: times, width check, drop count, into the output register
    // ---------------------------------------------------------------
    logic [24:0] n_start_ofs;   // end - tover, signed
    logic [25:0] n_peak_ofs;    // 2*end - tover, signed
    logic [63:0] n_peak_sum;
    logic        n_too_long;
    logic [31:0] r_drop;
    logic [31:0] n_drop;
    t_out_beat   n_out;
    t_out_beat   r_out;

    assign n_start_ofs = {1'b0, r_s2_end_clk} - {1'b0, r_s2_tover_clk};
    assign n_peak_ofs  = {1'b0, r_s2_end_clk, 1'b0} - {2'b00, r_s2_tover_clk};
    // start + end = 2*ts + 2*end - tover, modulo 2^64
    assign n_peak_sum  = {r_s2_ts[62:0], 1'b0} + {{38{n_peak_ofs[25]}}, n_peak_ofs};
    assign n_too_long  = r_s2_tover_clk > r_max_width;
    assign n_drop      = r_drop + 32'(n_too_long);

    always_comb begin
        n_out.start_time    = r_s2_ts + {{39{n_start_ofs[24]}}, n_start_ofs};
        n_out.peak_time     = {1'b0, n_peak_sum[63:1]};
        n_out.time_over     = r_s2_tover_clk;
        n_out.offl_chan     = r_s2_offline;
        n_out.charge_int    = r_s2_charge;
        n_out.charge_pk     = r_s2_charge_pk;
        n_out.too_long      = n_too_long;
        n_out.dropped_total = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_drop  <= 32'd0;
        end else if (en_out) begin
            r_out_v <= r_s2_v;
            // Count only primitives that really leave the pipe.
            if (r_s2_v) begin
                r_drop <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HTP_ASSERT_NEXT(a_map_write_no_beat, i_clk, i_rst_n,
        in_acc && (i_in.op == OpMapWrite), !r_s1_v)
    `HTP_ASSERT_NEXT(a_drop_increments, i_clk, i_rst_n,
        en_out && r_s2_v && n_too_long, r_drop == $past(r_drop) + 32'd1)
    `HTP_ASSERT_NEXT(a_stage2_holds, i_clk, i_rst_n,
        r_s2_v && !en2, r_s2_v && $stable(r_s2_tover_clk))

endmodule

@@ design/htp_chan_map.sv @@
module htp_chan_map #(
    parameter int NUM_CHANNELS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic                              i_wr_en,
    input  logic [$clog2(NUM_CHANNELS)-1:0]   i_addr,
    input  htp_pkg::t_map_entry               i_wr_data,
    output htp_pkg::t_map_entry               o_rd_data
);
    import htp_pkg::*;

    t_map_entry r_mem [NUM_CHANNELS];
    t_map_entry r_rd_data;

    // Single address port: a beat can write its entry and read its old value at once.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
